// ===== hdl/pip_pkg.sv =====
// Shared types and constants for the point-in-polygon test core.
// Used by pip_vertex_mem, pip_edge_eval and point_in_polygon_test_core.
package pip_pkg;

    localparam int MAX_VERTICES = 128;
    localparam int COORD_W      = 32;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int NUM_W        = 8;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int PADDR_W      = 3;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    localparam logic REG_NUM_VERTICES = 1'b0;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } vtx_t;

    typedef struct packed {
        logic busy;
        logic crossed;
    } eval_stat_t;

endpackage

// ===== hdl/point_in_polygon_test_core.sv =====
// Top level of the point-in-polygon test core (crossing-number rule).
// Depends on pip_pkg, pip_vertex_mem and pip_edge_eval.
//
//  port group   dir   handshake             contents
//  s_*          in    s_valid / s_ready     op, vertex_index, x, y
//  m_*          out   m_valid / m_ready     inside_res
//  APB          in    psel/penable/pready   num_vertices at byte address 0
//
// A load transfer writes the vertex store at the clock edge that takes it.
// A test walks the vertex store (n = num_vertices, capped at 128): n + 1 memory
// reads, one per cycle, set by the single read port; then the edge pipeline
// drains, and then the output register is loaded with the result.
// A test with n = 0 skips the reads and answers inside.
// Reset (aresetn, synchronous, active low) clears control and num_vertices; the
// vertex store is not cleared, so only written vertices may be tested against.
// The output register frees the input side: loads are taken while a result
// waits, and a finished test stalls only if the previous result is still held.
module point_in_polygon_test_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_op,
    input  logic [6:0]                  s_vertex_index,
    input  logic signed [31:0]          s_x,
    input  logic signed [31:0]          s_y,
    // result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_inside_res,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pip_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [pip_pkg::NUM_W-1:0] num_vertices_reg, num_vertices_next;
    logic [pip_pkg::CNT_W-1:0] n_reg, n_next;
    logic [pip_pkg::CNT_W-1:0] n_sat;
    logic [pip_pkg::CNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic [pip_pkg::CNT_W-1:0] rd_idx;
    logic                      rd_vld_reg, rd_first_reg;
    logic                      out_vld_reg, out_vld_next;
    logic                      out_inside_reg, out_inside_next;
    logic                      out_load;
    logic                      s_xfer, load_xfer, test_xfer, cfg_wr;
    logic                      rd_en;
    logic                      out_free;
    pip_pkg::vtx_t             pt_reg;
    pip_pkg::vtx_t             prev_reg;
    pip_pkg::vtx_t             rd_data;
    pip_pkg::vtx_t             s_vtx;
    pip_pkg::eval_stat_t       ev_stat;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        num_vertices_next = num_vertices_reg;
        if (cfg_wr && (paddr[2] == pip_pkg::REG_NUM_VERTICES)) begin
            num_vertices_next = pwdata[pip_pkg::NUM_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == pip_pkg::REG_NUM_VERTICES) begin
            prdata = 32'(num_vertices_reg);
        end
    end

    // ---------------- input side ----------------
    assign s_ready   = (state_reg == S_IDLE);
    assign s_xfer    = s_valid && s_ready;
    assign load_xfer = s_xfer && (s_op == pip_pkg::OP_LOAD);
    assign test_xfer = s_xfer && (s_op == pip_pkg::OP_TEST);
    assign s_vtx.x   = s_x;
    assign s_vtx.y   = s_y;

    // count above capacity saturates
    assign n_sat = (num_vertices_reg > pip_pkg::NUM_W'(pip_pkg::MAX_VERTICES))
                 ? pip_pkg::CNT_W'(pip_pkg::MAX_VERTICES)
                 : pip_pkg::CNT_W'(num_vertices_reg);

    // read order: vertex n-1 first (closing edge), then 0 .. n-1
    assign rd_idx = (rd_cnt_reg == '0) ? (n_reg - pip_pkg::CNT_W'(1))
                                       : (rd_cnt_reg - pip_pkg::CNT_W'(1));
    assign rd_en  = (state_reg == S_READ);

    assign out_free = !out_vld_reg || m_ready;

    // ---------------- sequencer ----------------
    always_comb begin
        state_next  = state_reg;
        n_next      = n_reg;
        rd_cnt_next = rd_cnt_reg;
        out_load    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (test_xfer) begin
                    n_next      = n_sat;
                    rd_cnt_next = '0;
                    state_next  = (n_sat == '0) ? S_DONE : S_READ;
                end
            end
            S_READ: begin
                rd_cnt_next = rd_cnt_reg + pip_pkg::CNT_W'(1);
                if (rd_cnt_reg == n_reg) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!rd_vld_reg && !ev_stat.busy) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------- output register ----------------
    always_comb begin
        out_vld_next    = out_vld_reg;
        out_inside_next = out_inside_reg;
        if (out_load) begin
            out_vld_next    = 1'b1;
            out_inside_next = (n_reg == '0) ? 1'b1 : ev_stat.crossed;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    assign m_valid      = out_vld_reg;
    assign m_inside_res = out_inside_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            num_vertices_reg <= '0;
            rd_vld_reg       <= 1'b0;
            rd_first_reg     <= 1'b0;
            out_vld_reg      <= 1'b0;
            rd_cnt_reg       <= '0;
        end else begin
            state_reg        <= state_next;
            num_vertices_reg <= num_vertices_next;
            rd_vld_reg       <= rd_en;
            rd_first_reg     <= rd_en && (rd_cnt_reg == '0);
            out_vld_reg      <= out_vld_next;
            rd_cnt_reg       <= rd_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg          <= n_next;
        out_inside_reg <= out_inside_next;
        if (test_xfer) begin
            pt_reg <= s_vtx;
        end
        if (rd_vld_reg) begin
            prev_reg <= rd_data;
        end
    end

    // ---------------- datapath ----------------
    pip_vertex_mem u_mem (
        .aclk    (aclk),
        .wr_en   (load_xfer),
        .wr_addr (s_vertex_index[pip_pkg::ADDR_W-1:0]),
        .wr_data (s_vtx),
        .rd_en   (rd_en),
        .rd_addr (rd_idx[pip_pkg::ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // edge (current read, previous read); first read only primes prev_reg
    pip_edge_eval u_eval (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr     (test_xfer),
        .in_vld  (rd_vld_reg && !rd_first_reg),
        .cur     (rd_data),
        .prev    (prev_reg),
        .pt      (pt_reg),
        .stat    (ev_stat)
    );

    // ---------------- assertions ----------------
    a_done_no_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) |-> (!rd_vld_reg && !ev_stat.busy))
        else $error("result taken while edge pipeline still active");

    a_read_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ) |-> (rd_cnt_reg <= n_reg))
        else $error("read counter ran past vertex count");

    a_out_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!out_vld_reg || m_ready))
        else $error("pending result overwritten");

    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (!rd_vld_reg && !ev_stat.busy))
        else $error("edge work in flight while idle");

    a_test_starts_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (test_xfer && (n_sat != '0)) |=> (state_reg == S_READ && rd_cnt_reg == '0))
        else $error("test transfer did not start vertex walk");

endmodule

// ===== hdl/pip_vertex_mem.sv =====
// Vertex store: one write port, one read port, registered read data.
// Depends on pip_pkg.
module pip_vertex_mem (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [pip_pkg::ADDR_W-1:0] wr_addr,
    input  pip_pkg::vtx_t             wr_data,
    input  logic                      rd_en,
    input  logic [pip_pkg::ADDR_W-1:0] rd_addr,
    output pip_pkg::vtx_t             rd_data
);

    pip_pkg::vtx_t mem [pip_pkg::MAX_VERTICES];
    pip_pkg::vtx_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/pip_edge_eval.sv =====
// Edge crossing evaluator: differences, cross products, compare, flag toggle.
// Depends on pip_pkg.
module pip_edge_eval (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  clr,
    input  logic                  in_vld,
    input  pip_pkg::vtx_t         cur,
    input  pip_pkg::vtx_t         prev,
    input  pip_pkg::vtx_t         pt,
    output pip_pkg::eval_stat_t   stat
);

    // stage 1: differences and straddle test
    logic                              s1_vld_reg, s1_vld_next;
    logic                              s1_strad_reg, s1_strad_next;
    logic                              s1_dyneg_reg, s1_dyneg_next;
    logic signed [pip_pkg::DIFF_W-1:0] s1_dxp_reg, s1_dxp_next;
    logic signed [pip_pkg::DIFF_W-1:0] s1_dy_reg, s1_dy_next;
    logic signed [pip_pkg::DIFF_W-1:0] s1_dxe_reg, s1_dxe_next;
    logic signed [pip_pkg::DIFF_W-1:0] s1_dyp_reg, s1_dyp_next;
    // stage 2: cross products
    logic                              s2_vld_reg;
    logic                              s2_strad_reg;
    logic                              s2_dyneg_reg;
    logic signed [pip_pkg::PROD_W-1:0] s2_lhs_reg, s2_lhs_next;
    logic signed [pip_pkg::PROD_W-1:0] s2_rhs_reg, s2_rhs_next;
    // stage 3: compare and toggle
    logic signed [pip_pkg::PROD_W:0]   cmp;
    logic                              lt, gt, tog;
    logic                              flag_reg, flag_next;

    always_comb begin
        s1_vld_next   = in_vld;
        s1_strad_next = (cur.y > pt.y) != (prev.y > pt.y);
        s1_dxp_next   = pip_pkg::DIFF_W'(pt.x)   - pip_pkg::DIFF_W'(cur.x);
        s1_dy_next    = pip_pkg::DIFF_W'(prev.y) - pip_pkg::DIFF_W'(cur.y);
        s1_dxe_next   = pip_pkg::DIFF_W'(prev.x) - pip_pkg::DIFF_W'(cur.x);
        s1_dyp_next   = pip_pkg::DIFF_W'(pt.y)   - pip_pkg::DIFF_W'(cur.y);
        s1_dyneg_next = s1_dy_next[pip_pkg::DIFF_W-1];
    end

    always_comb begin
        s2_lhs_next = s1_dxp_reg * s1_dy_reg;
        s2_rhs_next = s1_dxe_reg * s1_dyp_reg;
    end

    // straddling edge always has dy != 0, so the sign bit picks the direction
    always_comb begin
        cmp = (pip_pkg::PROD_W+1)'(s2_lhs_reg) - (pip_pkg::PROD_W+1)'(s2_rhs_reg);
        lt  = cmp[pip_pkg::PROD_W];
        gt  = !cmp[pip_pkg::PROD_W] && (cmp != '0);
        tog = s2_vld_reg && s2_strad_reg && (s2_dyneg_reg ? gt : lt);
        flag_next = clr ? 1'b0 : (flag_reg ^ tog);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            flag_reg   <= 1'b0;
        end else begin
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s1_vld_reg;
            flag_reg   <= flag_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_strad_reg <= s1_strad_next;
        s1_dyneg_reg <= s1_dyneg_next;
        s1_dxp_reg   <= s1_dxp_next;
        s1_dy_reg    <= s1_dy_next;
        s1_dxe_reg   <= s1_dxe_next;
        s1_dyp_reg   <= s1_dyp_next;
        s2_strad_reg <= s1_strad_reg;
        s2_dyneg_reg <= s1_dyneg_reg;
        s2_lhs_reg   <= s2_lhs_next;
        s2_rhs_reg   <= s2_rhs_next;
    end

    assign stat.busy    = s1_vld_reg || s2_vld_reg;
    assign stat.crossed = flag_reg;

endmodule
